@@ hdl/rsa_pkg.sv @@
// Running statistics accumulator: shared package.
// Field widths, reset values, datapath commands, controller states and the
// command and status structs between the controller and the datapath.
`timescale 1ns / 1ps

package rsa_pkg;

	localparam int SAMPLE_W = 24;
	localparam int KEY_W    = 17;
	localparam int CNT_W    = 16;
	localparam int MCNT_W   = 32;
	localparam int WIDE_W   = 64;
	localparam int SUM_W    = 41;
	localparam int SQ_W     = 47;
	localparam int VAR_W    = 47;
	localparam int OUT_W    = 224;
	localparam int WORD_W   = MCNT_W + KEY_W;

	localparam logic [CNT_W-1:0]    WEIGHT_RESET = 16'd1000;
	localparam logic [SAMPLE_W-1:0] MIN_RESET    = 24'h7FFFFF;
	localparam logic [SAMPLE_W-1:0] MAX_RESET    = 24'h800000;
	localparam logic [MCNT_W-1:0]   MCNT_MAX     = 32'hFFFFFFFF;

	// Input opcodes
	localparam logic OPC_ADD   = 1'b0;
	localparam logic OPC_FETCH = 1'b1;

	// Datapath commands
	typedef enum logic [4:0] {
		OP_NONE,
		OP_TAKE,
		OP_PLAIN,
		OP_LD_SUM,
		OP_LD_SSQ,
		OP_LD_MED,
		OP_DIV_CNT,
		OP_DIV_N1,
		OP_MUL_N,
		OP_ADD_V,
		OP_ADD_SQ,
		OP_ST_SUM,
		OP_ST_SSQ,
		OP_ST_MED,
		OP_ST_MEAN,
		OP_VAR,
		OP_SQRT,
		OP_MMX,
		OP_SCAN_RST,
		OP_RD,
		OP_CMPK,
		OP_HIT,
		OP_INS,
		OP_BEST,
		OP_LOAD_OUT
	} op_t;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_PLAIN,
		ST_W_LD_SUM,
		ST_W_DIV_SUM,
		ST_W_MUL_SUM,
		ST_W_ADD_SUM,
		ST_W_DIVN_SUM,
		ST_W_MULN_SUM,
		ST_W_ST_SUM,
		ST_W_LD_SSQ,
		ST_W_DIV_SSQ,
		ST_W_MUL_SSQ,
		ST_W_ADD_SSQ,
		ST_W_DIVN_SSQ,
		ST_W_MULN_SSQ,
		ST_W_ST_SSQ,
		ST_W_LD_MED,
		ST_W_MUL_MED,
		ST_W_ADD_MED,
		ST_W_DIVN_MED,
		ST_W_ST_MED,
		ST_MMX,
		ST_M_CHK,
		ST_M_CMP,
		ST_M_HIT,
		ST_M_INS,
		ST_F_LD_SUM,
		ST_F_DIV_SUM,
		ST_F_ST_MEAN,
		ST_F_LD_SSQ,
		ST_F_DIV_SSQ,
		ST_F_VAR,
		ST_F_SQRT,
		ST_F_SCAN,
		ST_F_CHK,
		ST_F_CMP,
		ST_F_OUT
	} state_t;

	typedef struct packed {
		op_t  op;
		logic sgn;   // signed division
	} cmd_t;

	typedef struct packed {
		logic weighted;  // count at or above the weight
		logic cnt_zero;
		logic done;      // a multi-cycle unit finished this cycle
		logic idx_end;   // mode scan index reached the fill count
		logic full;      // mode table full
		logic hit;       // read key equals the sample key
		logic out_free;  // output register can take a result
	} status_t;

endpackage

@@ hdl/rsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rsa_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/rsa_div.sv @@
// Restoring divider, one quotient bit per cycle, 64-bit dividend, 17-bit divisor.
// Truncates toward zero in signed mode. Uses rsa_pkg.
`timescale 1ns / 1ps

module rsa_div
	import rsa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              sgn,
	input  logic [WIDE_W-1:0] dividend,
	input  logic [CNT_W:0]    divisor,
	output logic              busy,
	output logic              done,
	output logic [WIDE_W-1:0] quotient
);

	logic              busy_q, done_q, neg_q;
	logic [5:0]        cnt_q;
	logic [WIDE_W-1:0] q_q;
	logic [CNT_W:0]    r_q, d_q;
	logic [CNT_W+1:0]  trial;
	logic              ge;

	// one trial subtraction per cycle
	assign trial = {r_q, q_q[WIDE_W-1]};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= sgn & dividend[WIDE_W-1];
			q_q   <= (sgn & dividend[WIDE_W-1]) ? (WIDE_W'(0) - dividend) : dividend;
			r_q   <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			r_q <= ge ? (CNT_W+1)'(trial - {1'b0, d_q}) : trial[CNT_W:0];
			q_q <= {q_q[WIDE_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? (WIDE_W'(0) - q_q) : q_q;

endmodule

@@ hdl/rsa_dp.sv @@
// Datapath: statistics registers, work register with shift-add multiplier,
// divider, square root unit, mode table and result register.
// Uses rsa_pkg, rsa_div and rsa_ram.
`timescale 1ns / 1ps

module rsa_dp
	import rsa_pkg::*;
#(
	parameter int MODE_SLOTS = 100
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output status_t             st,
	input  logic [SAMPLE_W-1:0] s_tdata,
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_wdata,
	input  logic                m_tready,
	output logic                m_tvalid,
	output logic                m_tuser,
	output logic [OUT_W-1:0]    m_tdata
);

	localparam int AW = (MODE_SLOTS > 1) ? $clog2(MODE_SLOTS) : 1;
	localparam int UW = $clog2(MODE_SLOTS + 1);

	// configuration
	logic [CNT_W-1:0] wl_q, n16;
	logic [CNT_W:0]   n1;

	// architectural state
	logic [CNT_W-1:0]    count_q;
	logic [SUM_W-1:0]    sum_q;
	logic [WIDE_W-1:0]   sumsq_q;
	logic [SAMPLE_W-1:0] min_q, max_q, last_q, median_q;
	logic [UW-1:0]       used_q, idx_q;

	// per-item working registers
	logic [SAMPLE_W-1:0] v_q, mean_q;
	logic [SQ_W-1:0]     sq_q;
	logic [KEY_W-1:0]    key_q, mode_q;
	logic [MCNT_W-1:0]   best_q;
	logic [WIDE_W-1:0]   w_q;
	logic [2*SAMPLE_W-1:0] mm_q;
	logic [VAR_W-1:0]    var_q;
	logic [SAMPLE_W-1:0] std_q;

	// result register
	logic             out_valid_q, out_has_q;
	logic [OUT_W-1:0] out_data_q;

	// input sample decode
	logic [SAMPLE_W-1:0]   vin;
	logic [SAMPLE_W:0]     vmag, vrnd;
	logic [KEY_W-1:0]      kmag, kin;
	logic [2*SAMPLE_W-1:0] vsq;

	assign vin  = s_tdata;
	assign vmag = vin[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {vin[SAMPLE_W-1], vin})
	                              : {1'b0, vin};
	assign vrnd = vmag + (SAMPLE_W+1)'(128);
	assign kmag = vrnd[SAMPLE_W:8];
	assign kin  = vin[SAMPLE_W-1] ? (KEY_W'(0) - kmag) : kmag;
	assign vsq  = 48'($signed(vin) * $signed(vin));

	assign n16 = (wl_q == '0) ? CNT_W'(1) : wl_q;
	assign n1  = {1'b0, n16} + (CNT_W+1)'(1);

	// divider
	logic              div_start, div_busy, div_done;
	logic [WIDE_W-1:0] div_quot;
	logic [CNT_W:0]    div_dsr;

	assign div_start = (cmd.op == OP_DIV_CNT || cmd.op == OP_DIV_N1) && !div_busy && !div_done;
	assign div_dsr   = (cmd.op == OP_DIV_CNT) ? {1'b0, count_q} : n1;

	rsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.sgn      (cmd.sgn),
		.dividend (w_q),
		.divisor  (div_dsr),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	// mode table: word is {count, key}
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;
	logic [KEY_W-1:0]  rk;
	logic [MCNT_W-1:0] rc, rc_inc;

	assign rk     = ram_rdata[KEY_W-1:0];
	assign rc     = ram_rdata[WORD_W-1:KEY_W];
	assign rc_inc = (rc == MCNT_MAX) ? rc : rc + MCNT_W'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = {rc_inc, rk};
		case (cmd.op)
			OP_HIT: begin
				ram_we = 1'b1;
			end
			OP_INS: begin
				ram_we    = 1'b1;
				ram_waddr = used_q[AW-1:0];
				ram_wdata = {MCNT_W'(1), key_q};
			end
			default: ;
		endcase
	end

	assign ram_re = (cmd.op == OP_RD);

	rsa_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MODE_SLOTS)
	) u_mode_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// shift-add multiply of the work register by the weight
	logic              mul_run_q, mul_fin_q;
	logic [3:0]        mul_cnt_q;
	logic [WIDE_W-1:0] mc_q, mp_q;
	logic [CNT_W-1:0]  mb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_run_q <= 1'b0;
			mul_fin_q <= 1'b0;
			mul_cnt_q <= '0;
		end else begin
			mul_fin_q <= 1'b0;
			if (cmd.op == OP_MUL_N && !mul_run_q && !mul_fin_q) begin
				mul_run_q <= 1'b1;
				mul_cnt_q <= '0;
			end else if (mul_run_q) begin
				mul_cnt_q <= mul_cnt_q + 4'd1;
				if (mul_cnt_q == 4'd15) begin
					mul_run_q <= 1'b0;
					mul_fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_MUL_N && !mul_run_q && !mul_fin_q) begin
			mc_q <= w_q;
			mb_q <= n16;
			mp_q <= '0;
		end else if (mul_run_q) begin
			mp_q <= mb_q[0] ? mp_q + mc_q : mp_q;
			mc_q <= {mc_q[WIDE_W-2:0], 1'b0};
			mb_q <= mb_q >> 1;
		end
	end

	// bitwise integer square root of the variance
	logic              sq_run_q, sq_fin_q;
	logic [SQ_W-1:0]   sx_q;
	logic [SQ_W:0]     sr_q, sb_q, s_trial;
	logic              s_ge;

	assign s_trial = sr_q + sb_q;
	assign s_ge    = {1'b0, sx_q} >= s_trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_run_q <= 1'b0;
			sq_fin_q <= 1'b0;
		end else begin
			sq_fin_q <= 1'b0;
			if (cmd.op == OP_SQRT && !sq_run_q && !sq_fin_q) begin
				sq_run_q <= 1'b1;
			end else if (sq_run_q && sb_q == (SQ_W+1)'(1)) begin
				sq_run_q <= 1'b0;
				sq_fin_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_SQRT && !sq_run_q && !sq_fin_q) begin
			sx_q <= var_q;
			sr_q <= '0;
			sb_q <= (SQ_W+1)'(1) << (SQ_W - 1);
		end else if (sq_run_q) begin
			sx_q <= s_ge ? SQ_W'({1'b0, sx_q} - s_trial) : sx_q;
			sr_q <= s_ge ? ((sr_q >> 1) + sb_q) : (sr_q >> 1);
			sb_q <= sb_q >> 2;
		end
	end

	// work register and per-item values
	logic [WIDE_W-1:0] var_diff;
	assign var_diff = (w_q > {16'd0, mm_q}) ? (w_q - {16'd0, mm_q}) : '0;

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_TAKE: begin
				v_q   <= vin;
				sq_q  <= vsq[SQ_W-1:0];
				key_q <= kin;
			end
			OP_LD_SUM: w_q <= {{(WIDE_W-SUM_W){sum_q[SUM_W-1]}}, sum_q};
			OP_LD_SSQ: w_q <= sumsq_q;
			OP_LD_MED: w_q <= {{(WIDE_W-SAMPLE_W){median_q[SAMPLE_W-1]}}, median_q};
			OP_DIV_CNT, OP_DIV_N1: begin
				if (div_done) w_q <= div_quot;
			end
			OP_MUL_N: begin
				if (mul_fin_q) w_q <= mp_q;
			end
			OP_ADD_V:  w_q <= w_q + {{(WIDE_W-SAMPLE_W){v_q[SAMPLE_W-1]}}, v_q};
			OP_ADD_SQ: w_q <= w_q + {{(WIDE_W-SQ_W){1'b0}}, sq_q};
			OP_ST_MEAN: begin
				mean_q <= w_q[SAMPLE_W-1:0];
				mm_q   <= 48'($signed(w_q[SAMPLE_W-1:0]) * $signed(w_q[SAMPLE_W-1:0]));
			end
			OP_VAR: var_q <= var_diff[VAR_W-1:0];
			OP_SQRT: begin
				if (sq_fin_q) std_q <= sr_q[SAMPLE_W-1:0];
			end
			OP_SCAN_RST: begin
				best_q <= '0;
				mode_q <= '0;
			end
			OP_BEST: begin
				if (rc > best_q || (rc == best_q && best_q != '0
				    && $signed(rk) < $signed(mode_q))) begin
					best_q <= rc;
					mode_q <= rk;
				end
			end
			default: ;
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= WEIGHT_RESET;
		end else if (cfg_we) begin
			wl_q <= cfg_wdata;
		end
	end

	// statistics state, scan index, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sum_q       <= '0;
			sumsq_q     <= '0;
			min_q       <= MIN_RESET;
			max_q       <= MAX_RESET;
			last_q      <= '0;
			median_q    <= '0;
			used_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result valid: set on load, cleared when taken
			if (cmd.op == OP_LOAD_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_PLAIN: begin
					count_q  <= count_q + CNT_W'(1);
					sum_q    <= sum_q + {{(SUM_W-SAMPLE_W){v_q[SAMPLE_W-1]}}, v_q};
					sumsq_q  <= sumsq_q + {{(WIDE_W-SQ_W){1'b0}}, sq_q};
					median_q <= v_q;
				end
				OP_ST_SUM: sum_q    <= w_q[SUM_W-1:0];
				OP_ST_SSQ: sumsq_q  <= w_q;
				OP_ST_MED: median_q <= w_q[SAMPLE_W-1:0];
				OP_MMX: begin
					if ($signed(v_q) < $signed(min_q)) min_q <= v_q;
					if ($signed(v_q) > $signed(max_q)) max_q <= v_q;
					last_q <= v_q;
					idx_q  <= '0;
				end
				OP_SCAN_RST: idx_q <= '0;
				OP_CMPK: begin
					if (rk != key_q) idx_q <= idx_q + UW'(1);
				end
				OP_BEST: idx_q <= idx_q + UW'(1);
				OP_INS:  used_q <= used_q + UW'(1);
				OP_LOAD_OUT: begin
					count_q     <= '0;
					sum_q       <= '0;
					sumsq_q     <= '0;
					min_q       <= MIN_RESET;
					max_q       <= MAX_RESET;
					median_q    <= '0;
					used_q      <= '0;
				end
				default: ;
			endcase
		end
	end

	// result payload, zero when nothing was accumulated
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD_OUT) begin
			out_has_q <= (count_q != '0);
			if (count_q == '0) begin
				out_data_q <= '0;
			end else begin
				out_data_q <= {last_q, std_q, var_q, mode_q, median_q, max_q, min_q,
				               mean_q, count_q};
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_has_q;
	assign m_tdata  = out_data_q;

	// status to the controller
	always_comb begin
		st.weighted = (count_q >= n16);
		st.cnt_zero = (count_q == '0);
		st.done     = div_done | mul_fin_q | sq_fin_q;
		st.idx_end  = (idx_q == used_q);
		st.full     = (used_q == UW'(MODE_SLOTS));
		st.hit      = (rk == key_q);
		st.out_free = !out_valid_q || m_tready;
	end

endmodule

@@ hdl/rsa_ctrl.sv @@
// Controller state machine: sequences add and fetch transactions through
// the datapath commands. Uses rsa_pkg.
`timescale 1ns / 1ps

module rsa_ctrl
	import rsa_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	input  logic    s_opcode,
	input  status_t st,
	output logic    s_tready,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd.op   = OP_NONE;
		cmd.sgn  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.op   = OP_TAKE;
				if (s_tvalid) begin
					if (s_opcode == OPC_ADD) begin
						state_d = st.weighted ? ST_W_LD_SUM : ST_PLAIN;
					end else begin
						state_d = st.cnt_zero ? ST_F_OUT : ST_F_LD_SUM;
					end
				end
			end
			ST_PLAIN: begin
				cmd.op  = OP_PLAIN;
				state_d = ST_MMX;
			end
			// weighted sum
			ST_W_LD_SUM: begin
				cmd.op  = OP_LD_SUM;
				state_d = ST_W_DIV_SUM;
			end
			ST_W_DIV_SUM: begin
				cmd.op = OP_DIV_CNT;
				if (st.done) state_d = ST_W_MUL_SUM;
			end
			ST_W_MUL_SUM: begin
				cmd.op = OP_MUL_N;
				if (st.done) state_d = ST_W_ADD_SUM;
			end
			ST_W_ADD_SUM: begin
				cmd.op  = OP_ADD_V;
				state_d = ST_W_DIVN_SUM;
			end
			ST_W_DIVN_SUM: begin
				cmd.op = OP_DIV_N1;
				if (st.done) state_d = ST_W_MULN_SUM;
			end
			ST_W_MULN_SUM: begin
				cmd.op = OP_MUL_N;
				if (st.done) state_d = ST_W_ST_SUM;
			end
			ST_W_ST_SUM: begin
				cmd.op  = OP_ST_SUM;
				state_d = ST_W_LD_SSQ;
			end
			// weighted sum of squares, unsigned
			ST_W_LD_SSQ: begin
				cmd.op  = OP_LD_SSQ;
				state_d = ST_W_DIV_SSQ;
			end
			ST_W_DIV_SSQ: begin
				cmd.op  = OP_DIV_CNT;
				cmd.sgn = 1'b0;
				if (st.done) state_d = ST_W_MUL_SSQ;
			end
			ST_W_MUL_SSQ: begin
				cmd.op = OP_MUL_N;
				if (st.done) state_d = ST_W_ADD_SSQ;
			end
			ST_W_ADD_SSQ: begin
				cmd.op  = OP_ADD_SQ;
				state_d = ST_W_DIVN_SSQ;
			end
			ST_W_DIVN_SSQ: begin
				cmd.op  = OP_DIV_N1;
				cmd.sgn = 1'b0;
				if (st.done) state_d = ST_W_MULN_SSQ;
			end
			ST_W_MULN_SSQ: begin
				cmd.op = OP_MUL_N;
				if (st.done) state_d = ST_W_ST_SSQ;
			end
			ST_W_ST_SSQ: begin
				cmd.op  = OP_ST_SSQ;
				state_d = ST_W_LD_MED;
			end
			// weighted median
			ST_W_LD_MED: begin
				cmd.op  = OP_LD_MED;
				state_d = ST_W_MUL_MED;
			end
			ST_W_MUL_MED: begin
				cmd.op = OP_MUL_N;
				if (st.done) state_d = ST_W_ADD_MED;
			end
			ST_W_ADD_MED: begin
				cmd.op  = OP_ADD_V;
				state_d = ST_W_DIVN_MED;
			end
			ST_W_DIVN_MED: begin
				cmd.op = OP_DIV_N1;
				if (st.done) state_d = ST_W_ST_MED;
			end
			ST_W_ST_MED: begin
				cmd.op  = OP_ST_MED;
				state_d = ST_MMX;
			end
			// min, max, last, then mode table lookup
			ST_MMX: begin
				cmd.op  = OP_MMX;
				state_d = ST_M_CHK;
			end
			ST_M_CHK: begin
				cmd.op = OP_RD;
				if (st.idx_end) begin
					state_d = st.full ? ST_IDLE : ST_M_INS;
				end else begin
					state_d = ST_M_CMP;
				end
			end
			ST_M_CMP: begin
				cmd.op  = OP_CMPK;
				state_d = st.hit ? ST_M_HIT : ST_M_CHK;
			end
			ST_M_HIT: begin
				cmd.op  = OP_HIT;
				state_d = ST_IDLE;
			end
			ST_M_INS: begin
				cmd.op  = OP_INS;
				state_d = ST_IDLE;
			end
			// fetch
			ST_F_LD_SUM: begin
				cmd.op  = OP_LD_SUM;
				state_d = ST_F_DIV_SUM;
			end
			ST_F_DIV_SUM: begin
				cmd.op = OP_DIV_CNT;
				if (st.done) state_d = ST_F_ST_MEAN;
			end
			ST_F_ST_MEAN: begin
				cmd.op  = OP_ST_MEAN;
				state_d = ST_F_LD_SSQ;
			end
			ST_F_LD_SSQ: begin
				cmd.op  = OP_LD_SSQ;
				state_d = ST_F_DIV_SSQ;
			end
			ST_F_DIV_SSQ: begin
				cmd.op  = OP_DIV_CNT;
				cmd.sgn = 1'b0;
				if (st.done) state_d = ST_F_VAR;
			end
			ST_F_VAR: begin
				cmd.op  = OP_VAR;
				state_d = ST_F_SQRT;
			end
			ST_F_SQRT: begin
				cmd.op = OP_SQRT;
				if (st.done) state_d = ST_F_SCAN;
			end
			ST_F_SCAN: begin
				cmd.op  = OP_SCAN_RST;
				state_d = ST_F_CHK;
			end
			ST_F_CHK: begin
				cmd.op  = OP_RD;
				state_d = st.idx_end ? ST_F_OUT : ST_F_CMP;
			end
			ST_F_CMP: begin
				cmd.op  = OP_BEST;
				state_d = ST_F_CHK;
			end
			ST_F_OUT: begin
				if (st.out_free) begin
					cmd.op  = OP_LOAD_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ hdl/running_statistics_accumulator_top.sv @@
// Running statistics accumulator, top level.
// Input channel s_*: tuser[0] = opcode (0 add sample, 1 fetch), tdata[23:0] = Q15.8 sample.
// Output channel m_*: one transaction per fetch; tuser[0] = has_data, tdata holds the
// statistics. Config: cfg_we / cfg_wdata write the weight limit (reset 1000).
// One transaction is processed at a time; s_tready is high only in the idle state.
// Add, below the weight: a plain update, then min, max and last and the mode table scan
// (one RAM read per key in use). Add, at the weight: the sum, sum of squares and median
// are reweighted first by five divides and five multiplies on the shared work register.
// Fetch: two divides, a 24-step square root and the mode scan; an empty fetch goes
// straight from the idle state to loading the output register.
// The result sits in an output register; a new transaction is accepted while it
// waits. If the receiver stalls, a following fetch holds in its last step until
// the register is free.
// Reset (arst_n low) clears all statistics, the mode table fill count and the
// output valid; the weight limit returns to 1000. Mode table entries are not
// cleared; only the first fill-count entries are ever read.
`timescale 1ns / 1ps

module running_statistics_accumulator_top
	import rsa_pkg::*;
#(
	parameter int MODE_SLOTS = 100
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [SAMPLE_W-1:0] s_tdata,   // [23:0] sample
	input  logic                s_tuser,   // [0] opcode
	output logic                m_tvalid,
	input  logic                m_tready,
	// [15:0] sample_count, [39:16] mean_value, [63:40] smallest, [87:64] largest,
	// [111:88] median_estimate, [128:112] mode_value, [175:129] variance_value,
	// [199:176] std_deviation, [223:200] last_sample
	output logic [OUT_W-1:0]    m_tdata,
	output logic                m_tuser,   // [0] has_data
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_wdata
);

	cmd_t    cmd;
	status_t st;

	rsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_opcode (s_tuser),
		.st       (st),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	rsa_dp #(
		.MODE_SLOTS (MODE_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata)
	);

	// a result is never loaded over one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_LOAD_OUT |-> (!m_tvalid || m_tready))
		else $error("result loaded over a pending output transaction");

	// loading a result clears the statistics and presents the result
	a_clear_on_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_LOAD_OUT |=> (st.cnt_zero && m_tvalid))
		else $error("fetch did not clear statistics or present a result");

	// an accepted transaction always takes the block out of idle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted in back-to-back cycles");

endmodule

@@ bench/rsa_stats_checker.sv @@
// Running statistics accumulator: stream checker for the testbench.
// Watches the sample, result and weight-limit channels, predicts each fetch
// result from its own copy of the statistics, and compares. Uses rsa_pkg.
`timescale 1ns / 1ps

module rsa_stats_checker
	import rsa_pkg::*;
#(
	parameter int MODE_SLOTS = 100
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [SAMPLE_W-1:0] s_tdata,   // [23:0] sample
	input  logic                s_tuser,   // [0] opcode
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [OUT_W-1:0]    m_tdata,
	input  logic                m_tuser,   // [0] has_data
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_wdata,
	output int                  fail_count,
	output int                  pending
);

	typedef struct packed {
		logic                has_data;
		logic [CNT_W-1:0]    sample_count;
		logic [SAMPLE_W-1:0] mean_value;
		logic [SAMPLE_W-1:0] smallest;
		logic [SAMPLE_W-1:0] largest;
		logic [SAMPLE_W-1:0] median_estimate;
		logic [KEY_W-1:0]    mode_value;
		logic [VAR_W-1:0]    variance_value;
		logic [SAMPLE_W-1:0] std_deviation;
		logic [SAMPLE_W-1:0] last_sample;
	} stats_t;

	// running state of the predictor
	logic [CNT_W-1:0] weight;
	longint           n_samples;
	longint           run_sum;
	longint unsigned  run_sumsq;
	longint           lo_val, hi_val, last_val, median_val;
	int               key_tab [MODE_SLOTS];
	longint unsigned  key_hits [MODE_SLOTS];
	int               keys_used;
	stats_t           fetch_q[$];
	int               mismatches;

	assign pending = fetch_q.size();

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned root, b;
		root = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= root + b) begin
				x = x - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic void clear_stats();
		n_samples  = 0;
		run_sum    = 0;
		run_sumsq  = 0;
		lo_val     = 8388607;
		hi_val     = -8388608;
		median_val = 0;
		keys_used  = 0;
	endfunction

	function automatic void take_sample(longint v);
		longint          n, a;
		longint unsigned sq, asq, un;
		int              key;
		bit              found;
		n  = (weight == 0) ? 1 : longint'(weight);
		un = n;
		sq = v * v;
		if (n_samples < n) begin
			n_samples++;
			run_sum    = run_sum + v;
			run_sumsq  = run_sumsq + sq;
			median_val = v;
		end else begin
			// weighted phase: old average weight n, new sample weight 1
			a          = run_sum / n_samples;
			asq        = run_sumsq / longint'(n_samples);
			run_sum    = ((n * a + v) / (n + 1)) * n;
			run_sumsq  = ((un * asq + sq) / (un + 1)) * un;
			median_val = (n * median_val + v) / (n + 1);
		end
		if (v < lo_val) lo_val = v;
		if (v > hi_val) hi_val = v;
		last_val = v;
		// key: sample rounded half away from zero
		if (v >= 0) key = int'((v + 128) >>> 8);
		else        key = -int'(((-v) + 128) >>> 8);
		found = 0;
		for (int i = 0; i < keys_used; i++) begin
			if (!found && key_tab[i] == key) begin
				found = 1;
				if (key_hits[i] != 64'hFFFFFFFF) key_hits[i]++;
			end
		end
		if (!found && keys_used < MODE_SLOTS) begin
			key_tab[keys_used]  = key;
			key_hits[keys_used] = 1;
			keys_used++;
		end
	endfunction

	function automatic stats_t fetch_stats();
		stats_t          r;
		longint          mean;
		longint unsigned msq, mm, var_v, best;
		int              mode;
		r = '0;
		if (n_samples != 0) begin
			mean  = run_sum / n_samples;
			msq   = run_sumsq / longint'(n_samples);
			mm    = mean * mean;
			var_v = (msq > mm) ? msq - mm : 0;
			var_v = var_v & 64'h7FFF_FFFF_FFFF;
			best  = 0;
			mode  = 0;
			for (int i = 0; i < keys_used; i++) begin
				if (key_hits[i] > best ||
				    (key_hits[i] == best && best != 0 && key_tab[i] < mode)) begin
					best = key_hits[i];
					mode = key_tab[i];
				end
			end
			r.has_data        = 1'b1;
			r.sample_count    = n_samples[CNT_W-1:0];
			r.mean_value      = mean[SAMPLE_W-1:0];
			r.smallest        = lo_val[SAMPLE_W-1:0];
			r.largest         = hi_val[SAMPLE_W-1:0];
			r.median_estimate = median_val[SAMPLE_W-1:0];
			r.mode_value      = mode[KEY_W-1:0];
			r.variance_value  = var_v[VAR_W-1:0];
			r.std_deviation   = SAMPLE_W'(int_sqrt(var_v));
			r.last_sample     = last_val[SAMPLE_W-1:0];
		end
		clear_stats();
		return r;
	endfunction

	function automatic void cmp_field(string fname, longint unsigned exp_v,
	                                  longint unsigned act_v);
		if (exp_v != act_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t mismatch %s: expected %h, got %h", $realtime, fname, exp_v, act_v);
		end
	endfunction

	// track inputs and config, check each result transaction
	always @(posedge clk or negedge arst_n) begin
		stats_t got, want;
		if (!arst_n) begin
			weight     = WEIGHT_RESET;
			last_val   = 0;
			clear_stats();
			fetch_q.delete();
			mismatches = 0;
			fail_count = 0;
		end else begin
			if (cfg_we) weight = cfg_wdata;
			if (s_tvalid && s_tready) begin
				if (s_tuser == OPC_ADD) take_sample(longint'($signed(s_tdata)));
				else                    fetch_q.insert(fetch_q.size(), fetch_stats());
			end
			if (m_tvalid && m_tready) begin
				got.has_data        = m_tuser;
				got.sample_count    = m_tdata[15:0];
				got.mean_value      = m_tdata[39:16];
				got.smallest        = m_tdata[63:40];
				got.largest         = m_tdata[87:64];
				got.median_estimate = m_tdata[111:88];
				got.mode_value      = m_tdata[128:112];
				got.variance_value  = m_tdata[175:129];
				got.std_deviation   = m_tdata[199:176];
				got.last_sample     = m_tdata[223:200];
				if (fetch_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t result transaction with no fetch pending", $realtime);
				end else begin
					want = fetch_q.pop_front();
					cmp_field("has_data", 64'(want.has_data), 64'(got.has_data));
					cmp_field("sample_count", 64'(want.sample_count),
					          64'(got.sample_count));
					cmp_field("mean_value", 64'(want.mean_value), 64'(got.mean_value));
					cmp_field("smallest", 64'(want.smallest), 64'(got.smallest));
					cmp_field("largest", 64'(want.largest), 64'(got.largest));
					cmp_field("median_estimate", 64'(want.median_estimate),
					          64'(got.median_estimate));
					cmp_field("mode_value", 64'(want.mode_value), 64'(got.mode_value));
					cmp_field("variance_value", 64'(want.variance_value),
					          64'(got.variance_value));
					cmp_field("std_deviation", 64'(want.std_deviation),
					          64'(got.std_deviation));
					cmp_field("last_sample", 64'(want.last_sample), 64'(got.last_sample));
				end
				fail_count = mismatches;
			end
		end
	end

endmodule

@@ bench/testbench.sv @@
// Running statistics accumulator: testbench top.
// Drives samples, fetches and weight-limit writes with random stalls on both
// sides; rsa_stats_checker predicts and compares. Needs rsa_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
	import rsa_pkg::*;

	localparam int WATCHDOG = 40000;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                s_tvalid = 0;
	logic                s_tready;
	logic [SAMPLE_W-1:0] s_tdata = '0;
	logic                s_tuser = OPC_ADD;
	logic                m_tvalid;
	logic                m_tready = 0;
	logic [OUT_W-1:0]    m_tdata;
	logic                m_tuser;
	logic                cfg_we = 0;
	logic [CNT_W-1:0]    cfg_wdata = '0;
	int                  fail_count, pending;
	int                  src_idle = 28, sink_idle = 62;
	int                  n_sent = 0;
	int                  quiet = 0;

	always #10 clk = ~clk;

	running_statistics_accumulator_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	rsa_stats_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending)
	);

	// receiver stalls
	always @(negedge clk) m_tready <= ($urandom_range(99) >= sink_idle);

	// watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// one input transaction, with random gaps ahead of it
	task automatic send(input logic opc, input logic [SAMPLE_W-1:0] v);
		bit gap;
		gap = 0;
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			if (!gap) s_tvalid <= 1'b0;
			gap = 1;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= opc;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		n_sent++;
		if (n_sent == 600) begin src_idle = 62; sink_idle = 28; end
		if (n_sent == 1200) begin src_idle = 0; sink_idle = 0; end
	endtask

	// drain results, let the block settle, then write the weight limit
	task automatic set_weight(input logic [CNT_W-1:0] w);
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		do @(posedge clk); while (!s_tready);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample(input int style);
		case (style)
			0: return SAMPLE_W'($urandom_range(1535)) - 24'd768;  // few keys: ties
			1: return $urandom_range(1) ? MIN_RESET : MAX_RESET;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// a run of adds and then usually a fetch
	task automatic run_burst(input bit end_fetch);
		int len, style;
		style = $urandom_range(3);
		case ($urandom_range(9))
			0:       len = $urandom_range(130, 100);  // long enough to fill the mode table
			1:       len = 0;
			default: len = $urandom_range(20, 1);
		endcase
		if (style == 3 && len > 0) style = $urandom_range(2);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(19) == 0) send(OPC_ADD, pick_sample(1));
			else                         send(OPC_ADD, pick_sample(style));
		end
		if (end_fetch) send(OPC_FETCH, SAMPLE_W'($urandom));
	endtask

	initial begin
		logic [CNT_W-1:0] weights [7];
		int               n_random;
		weights = '{16'd1, 16'd0, 16'd65535, 16'd3, 16'd20, 16'd2, 16'd1000};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty fetch, extremes, rounding edges, ties, fetch after a clear
		send(OPC_FETCH, '0);
		send(OPC_ADD, 24'h7FFFFF);
		send(OPC_ADD, 24'h800000);
		send(OPC_ADD, 24'd0);
		send(OPC_ADD, 24'd127);
		send(OPC_ADD, 24'd128);
		send(OPC_ADD, -24'sd128);
		send(OPC_ADD, -24'sd129);
		send(OPC_ADD, 24'd384);
		send(OPC_ADD, -24'sd384);
		send(OPC_FETCH, 24'hFFFFFF);
		send(OPC_FETCH, '0);
		send(OPC_ADD, 24'd512);
		send(OPC_ADD, -24'sd512);
		send(OPC_ADD, 24'h5A5A5A);
		send(OPC_FETCH, '0);

		// random: several weight settings; some bursts end without a fetch so the count
		// carries over into the next weight setting, in some steps a lower one
		n_random = 0;
		for (int p = 0; p < 8; p++) begin
			if (p > 0) set_weight(p == 7 ? CNT_W'($urandom_range(65535, 1)) : weights[p-1]);
			while (n_random < (p + 1) * 225) begin
				if ($urandom_range(49) == 0) begin
					// sender pauses until every result is back
					@(negedge clk);
					s_tvalid <= 1'b0;
					wait (pending == 0);
				end
				run_burst($urandom_range(5) != 0);
				n_random = n_sent;
			end
		end
		send(OPC_FETCH, '0);

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (1000) @(posedge clk);
		if (fail_count == 0 && pending == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule

@@ running_statistics_accumulator_top.f @@
hdl/rsa_pkg.sv
hdl/rsa_ram.sv
hdl/rsa_div.sv
hdl/rsa_dp.sv
hdl/rsa_ctrl.sv
hdl/running_statistics_accumulator_top.sv
bench/rsa_stats_checker.sv
bench/testbench.sv
